FILE: src/mmm_pkg.sv
// Package: opcodes, widths and queue entry type for the Montgomery multiplier.
`default_nettype none
package mmm_pkg;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned IDX_W  = 2;

  typedef enum logic [1:0] {
    OP_LOAD_MOD  = 2'd0,
    OP_LOAD_NP   = 2'd1,
    OP_OPERAND   = 2'd2,
    OP_RESERVED  = 2'd3
  } opcode_t;

  // Classified work for the back end.
  typedef struct packed {
    opcode_t           op;
    logic [IDX_W-1:0]  idx;
    logic              start;   // last operand word: run the product
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_AB,
    PH_MNP,
    PH_MN
  } phase_t;
endpackage
`default_nettype wire

FILE: src/mmm_if.sv
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface mmm_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/mmm_front.sv
// Front end: filter and classify input items, push commands into a small queue.
`default_nettype none
module mmm_front #(
  parameter int unsigned NUM_WORDS = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      in_opcode,
  input  wire logic [1:0]      in_word_index,
  input  wire logic [63:0]     in_a_word,
  input  wire logic [63:0]     in_b_word,
  output logic                 q_valid,
  input  wire logic            q_ready,
  output mmm_pkg::cmd_t        q_cmd
);
  import mmm_pkg::*;

  localparam int unsigned DEPTH = 2;

  cmd_t        fifo_r [DEPTH];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  cmd_t        cmd;
  logic        keep, push, pop;

  always_comb begin
    cmd.op    = opcode_t'(in_opcode);
    cmd.idx   = in_word_index;
    cmd.a     = in_a_word;
    cmd.b     = in_b_word;
    cmd.start = (in_opcode == OP_OPERAND) &&
                ({30'd0, in_word_index} == 32'(NUM_WORDS - 1));
    // drop reserved opcodes and out-of-range indexes
    keep = (in_opcode != OP_RESERVED) && ({30'd0, in_word_index} < 32'(NUM_WORDS));
  end

  assign in_ready = (cnt_r != 2'(DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: src/mmm_back.sv
// Back end: word stores, one shared 32x32 multiplier, product schedule, result emit.
`default_nettype none
module mmm_back #(
  parameter int unsigned NUM_WORDS = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire mmm_pkg::cmd_t q_cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_result_index,
  output logic [63:0]        out_result_word,
  output logic               out_last
);
  import mmm_pkg::*;

  localparam int unsigned NW  = NUM_WORDS;
  localparam int unsigned IW  = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned TW  = $clog2(2 * NW);
  localparam int unsigned TWD = 2 * NW;

  logic [63:0] mod_r [NW];
  logic [63:0] np_r  [NW];
  logic [63:0] a_r   [NW];
  logic [63:0] b_r   [NW];
  logic [63:0] m_r   [NW];
  logic [63:0] t_r   [TWD];

  state_t      st_r, st_nxt;
  phase_t      ph_r;
  logic [IW:0] i_r, j_r;
  logic [1:0]  mq_r;
  logic [63:0] carry_r;
  logic [127:0] prod_r;
  logic [IW:0] e_r;
  logic        ovld_r;
  logic [63:0] oword_r;
  logic [1:0]  oidx_r;
  logic        olast_r;

  logic [IW-1:0] ii, jj;
  logic [63:0]   opx, opy;
  logic [31:0]   mx, my;
  logic [63:0]   pp;
  logic          mul_zero;
  logic [TW:0]   pos;
  logic [TW-1:0] posi;
  logic          accm;     // accumulating into m instead of t
  logic [63:0]   accv;
  logic [128:0]  sum;
  logic          row_end;

  assign ii   = i_r[IW-1:0];
  assign jj   = j_r[IW-1:0];
  assign accm = (ph_r == PH_MNP);
  assign pos  = (TW+1)'(i_r) + (TW+1)'(j_r);
  assign posi = pos[TW-1:0];

  // operand selection for the shared multiplier
  always_comb begin
    case (ph_r)
      PH_AB:   begin opx = a_r[ii]; opy = b_r[jj]; end
      PH_MNP:  begin opx = t_r[ii]; opy = np_r[jj]; end
      PH_MN:   begin opx = m_r[ii]; opy = mod_r[jj]; end
      default: begin opx = a_r[ii]; opy = b_r[jj]; end
    endcase
  end

  // one 32x32 multiplier: four half-word products summed into prod_r
  assign mul_zero = (j_r >= (IW+1)'(NW));
  assign mx       = mq_r[1] ? opx[63:32] : opx[31:0];
  assign my       = mq_r[0] ? opy[63:32] : opy[31:0];
  assign pp       = mx * my;

  // j runs to the end of the accumulator (truncated), carrying past y's words
  always_comb begin
    accv    = accm ? m_r[pos[IW-1:0]] : t_r[posi];
    sum     = {65'd0, accv} + {1'b0, prod_r} + {65'd0, carry_r};
    row_end = accm ? (pos + 1'b1 >= (TW+1)'(NW)) : (pos + 1'b1 >= (TW+1)'(TWD));
  end

  assign q_ready = (st_r == ST_IDLE) && !(q_valid && q_cmd.start && ovld_r);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid && q_ready && q_cmd.start) st_nxt = ST_MUL;
      ST_MUL:  if (mul_zero || mq_r == 2'd3) st_nxt = ST_ACC;
      ST_ACC: begin
        if (row_end && i_r == (IW+1)'(NW - 1))
          st_nxt = (ph_r == PH_MN) ? ST_EMIT : ST_MUL;
        else
          st_nxt = ST_MUL;
      end
      ST_EMIT: if (!ovld_r || out_ready) begin
        if (e_r == (IW+1)'(NW - 1)) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // store writes from the queue
  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      case (q_cmd.op)
        OP_LOAD_MOD: mod_r[q_cmd.idx[IW-1:0]] <= q_cmd.a;
        OP_LOAD_NP:  np_r[q_cmd.idx[IW-1:0]]  <= q_cmd.a;
        OP_OPERAND: begin
          a_r[q_cmd.idx[IW-1:0]] <= q_cmd.a;
          b_r[q_cmd.idx[IW-1:0]] <= q_cmd.b;
        end
        default: ;
      endcase
    end
  end

  // multiply-accumulate datapath
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_valid && q_ready && q_cmd.start) begin
      for (int k = 0; k < TWD; k++) t_r[k] <= '0;
      for (int k = 0; k < NW; k++)  m_r[k] <= '0;
    end
    if (st_r == ST_MUL) begin
      if (mul_zero) begin
        prod_r <= '0;
      end else begin
        case (mq_r)
          2'd0:       prod_r <= {64'd0, pp};
          2'd1, 2'd2: prod_r <= prod_r + {32'd0, pp, 32'd0};
          default:    prod_r <= prod_r + {pp, 64'd0};
        endcase
      end
    end
    if (st_r == ST_ACC) begin
      if (accm) m_r[pos[IW-1:0]] <= sum[63:0];
      else      t_r[posi]        <= sum[63:0];
      carry_r <= row_end ? 64'd0 : sum[127:64];
    end else if (st_r == ST_IDLE) begin
      carry_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ph_r <= PH_AB;
      i_r  <= '0;
      j_r  <= '0;
      mq_r <= '0;
      e_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_IDLE) begin
        ph_r <= PH_AB; i_r <= '0; j_r <= '0; mq_r <= '0; e_r <= '0;
      end
      if (st_r == ST_MUL) begin
        mq_r <= (mul_zero || mq_r == 2'd3) ? 2'd0 : mq_r + 2'd1;
      end
      if (st_r == ST_ACC) begin
        if (row_end) begin
          j_r <= '0;
          if (i_r == (IW+1)'(NW - 1)) begin
            i_r <= '0;
            if (ph_r == PH_AB)       ph_r <= PH_MNP;
            else if (ph_r == PH_MNP) ph_r <= PH_MN;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      if (st_r == ST_EMIT && (!ovld_r || out_ready)) e_r <= e_r + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (st_r == ST_EMIT && (!ovld_r || out_ready)) begin
      ovld_r  <= 1'b1;
      oword_r <= t_r[TW'(NW) + TW'(e_r[IW-1:0])];
      oidx_r  <= 2'(e_r);
      olast_r <= (e_r == (IW+1)'(NW - 1));
    end else if (out_ready) begin
      ovld_r <= 1'b0;
    end
  end

  assign out_valid        = ovld_r;
  assign out_result_index = oidx_r;
  assign out_result_word  = oword_r;
  assign out_last         = olast_r;
endmodule
`default_nettype wire

FILE: src/montgomery_modular_multiplier.sv
// Top level: multi-word Montgomery multiplier, front end, command queue and back end.
//
//   channel  | direction | payload
//   in_*     | sink      | opcode, word_index, a_word, b_word
//   out_*    | source    | result_index, result_word, last
//
// Load and non-final operand items pass the two-entry queue at one per cycle while
// the back end is idle. The final operand word starts the product: a*b, the truncated
// low half of t*n' and m*N on one shared 32x32 multiplier, each word product as four
// half-word multiply steps and one accumulate step, each carry-spill step as a zeroed
// multiply and an accumulate; result words then leave one per cycle while out_ready
// holds. Reset is synchronous, active low, and clears control only. The queue
// fills and in_ready drops while a product runs; the output register holds under stall.
`default_nettype none
module montgomery_modular_multiplier #(
  parameter int unsigned NUM_WORDS = 4
) (
  input wire logic clk,
  input wire logic rst_n,
  mmm_if.sink      in_ch,
  mmm_if.source    out_ch
);
  import mmm_pkg::*;

  logic  q_valid, q_ready;
  cmd_t  q_cmd;

  // in_ch.data = {opcode, word_index, a_word, b_word}
  mmm_front #(.NUM_WORDS(NUM_WORDS)) u_front (
    .clk, .rst_n,
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_opcode     (in_ch.data[131:130]),
    .in_word_index (in_ch.data[129:128]),
    .in_a_word     (in_ch.data[127:64]),
    .in_b_word     (in_ch.data[63:0]),
    .q_valid, .q_ready, .q_cmd
  );

  // out_ch.data = {result_index, result_word, last}
  mmm_back #(.NUM_WORDS(NUM_WORDS)) u_back (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_cmd,
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_result_index (out_ch.data[66:65]),
    .out_result_word  (out_ch.data[64:1]),
    .out_last         (out_ch.data[0])
  );

  // a stalled result must hold
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  // a granted queue command must have a known opcode
  a_q: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready && q_valid |-> !$isunknown(q_cmd.op))
    else $error("queue command unknown");
endmodule
`default_nettype wire

FILE: tb/sv/montgomery_modular_multiplier_checker.sv
// Checker: watches both channels, predicts Montgomery products and compares result words.
`timescale 1ns / 100ps
module montgomery_modular_multiplier_checker #(
  parameter int unsigned NUM_WORDS = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_ready,
  input  wire logic [131:0] in_data,
  input  wire logic         out_valid,
  input  wire logic         out_ready,
  input  wire logic [66:0]  out_data,
  output int unsigned       fail_count,
  output int unsigned       pending_words,
  output int unsigned       products_seen
);
  import mmm_pkg::*;

  localparam int unsigned BITS = WORD_W * NUM_WORDS;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
    logic              last;
  } result_word_t;

  logic [WORD_W-1:0] modulus_w [NUM_WORDS];
  logic [WORD_W-1:0] nprime_w  [NUM_WORDS];
  logic [WORD_W-1:0] op_a_w    [NUM_WORDS];
  logic [WORD_W-1:0] op_b_w    [NUM_WORDS];
  result_word_t      product_words [$];

  initial begin
    fail_count    = 0;
    products_seen = 0;
    pending_words = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Multiply a*b, reduce with n', add m*N and keep the upper half.
  task automatic predict_product();
    logic [BITS-1:0]   a_val, b_val, n_val, np_val, m_val;
    logic [2*BITS-1:0] t_val;
    result_word_t      rw;
    for (int k = 0; k < NUM_WORDS; k++) begin
      a_val[k*WORD_W +: WORD_W]  = op_a_w[k];
      b_val[k*WORD_W +: WORD_W]  = op_b_w[k];
      n_val[k*WORD_W +: WORD_W]  = modulus_w[k];
      np_val[k*WORD_W +: WORD_W] = nprime_w[k];
    end
    t_val = {{BITS{1'b0}}, a_val} * {{BITS{1'b0}}, b_val};
    m_val = t_val[BITS-1:0] * np_val;
    t_val = t_val + {{BITS{1'b0}}, m_val} * {{BITS{1'b0}}, n_val};
    for (int k = 0; k < NUM_WORDS; k++) begin
      rw.idx  = k[IDX_W-1:0];
      rw.word = t_val[BITS + k*WORD_W +: WORD_W];
      rw.last = (k == NUM_WORDS - 1);
      product_words.push_back(rw);
    end
  endtask

  always @(posedge clk) begin
    opcode_t           op;
    logic [IDX_W-1:0]  idx;
    result_word_t      got, want;
    if (rst_n && in_valid && in_ready) begin
      op  = opcode_t'(in_data[131:130]);
      idx = in_data[129:128];
      if (idx < NUM_WORDS) begin
        case (op)
          OP_LOAD_MOD: modulus_w[idx] = in_data[127:64];
          OP_LOAD_NP:  nprime_w[idx]  = in_data[127:64];
          OP_OPERAND: begin
            op_a_w[idx] = in_data[127:64];
            op_b_w[idx] = in_data[63:0];
            if (idx == NUM_WORDS - 1) begin
              predict_product();
            end
          end
          default: ;
        endcase
      end
    end
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (product_words.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", got.word));
      end else begin
        want = product_words.pop_front();
        if (got.idx != want.idx)
          report_mismatch($sformatf("index %0d, want %0d", got.idx, want.idx));
        if (got.word != want.word)
          report_mismatch($sformatf("word[%0d] %h, want %h", want.idx, got.word, want.word));
        if (got.last != want.last)
          report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        if (want.last) products_seen++;
      end
    end
    pending_words = product_words.size();
  end
endmodule

FILE: tb/sv/montgomery_modular_multiplier_tb.sv
// Testbench top: drives operand and load items, stalls the result side, gives the verdict.
`timescale 1ns / 100ps
module montgomery_modular_multiplier_tb;
  import mmm_pkg::*;

  localparam int unsigned NUM_WORDS  = 4;
  localparam int unsigned ITEM_GOAL  = 230;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned DRAIN_CYC  = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mmm_if #(.W(132)) in_ch ();
  mmm_if #(.W(67))  out_ch ();

  int unsigned fail_count, pending_words, products_seen;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  bit          steady_in = 0;    // when set, send back to back
  int unsigned stall_left = 0;

  always #5 clk = ~clk;

  montgomery_modular_multiplier #(.NUM_WORDS(NUM_WORDS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  montgomery_modular_multiplier_checker #(.NUM_WORDS(NUM_WORDS)) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data       (in_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_ch.data),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .products_seen (products_seen)
  );

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Word values with the extremes mixed in.
  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1;
      3: return 64'h8000_0000_0000_0000;
      4: return {$urandom, $urandom} & {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Result side: random stalls, with stretches of constant ready.
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ch.ready <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? 0 : 0;
    end
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Hold the item until accepted, then optionally drop valid for a gap.
  task automatic send_item(input opcode_t op, input logic [IDX_W-1:0] idx,
                           input logic [63:0] a, input logic [63:0] b);
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= {op, idx, a, b};
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Load every modulus and n-prime word with the given values.
  task automatic load_key(input logic [63:0] n_word, input logic [63:0] np_word);
    for (int k = 0; k < NUM_WORDS; k++) begin
      send_item(OP_LOAD_MOD, k[IDX_W-1:0], n_word, pick_word());
      send_item(OP_LOAD_NP, k[IDX_W-1:0], np_word, pick_word());
    end
  endtask

  // Full operand sequence, low word first; the top word starts the product.
  task automatic send_operands(input int kind);
    logic [63:0] a, b;
    for (int k = 0; k < NUM_WORDS; k++) begin
      case (kind)
        0: begin a = '0; b = '0; end
        1: begin a = '1; b = '1; end
        default: begin a = pick_word(); b = pick_word(); end
      endcase
      send_item(OP_OPERAND, k[IDX_W-1:0], a, b);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme keys and operands, ignored opcode, partial overwrite.
    load_key('1, '1);
    send_operands(0);
    send_operands(1);
    send_item(OP_RESERVED, 2'd3, '1, '1);
    send_item(OP_OPERAND, 2'd1, '0, '1);
    send_item(OP_OPERAND, 2'd3, '1, '0);

    // Random: mostly complete products, with key reloads, stray words and noise.
    while (items_sent < ITEM_GOAL) begin
      steady_in = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 11))
        0: send_item(OP_LOAD_MOD, IDX_W'($urandom_range(0, NUM_WORDS - 1)),
                     pick_word(), pick_word());
        1: send_item(OP_LOAD_NP, IDX_W'($urandom_range(0, NUM_WORDS - 1)),
                     pick_word(), pick_word());
        2: send_item(OP_RESERVED, IDX_W'($urandom_range(0, 3)), pick_word(), pick_word());
        3: send_item(OP_OPERAND, IDX_W'($urandom_range(0, NUM_WORDS - 1)),
                     pick_word(), pick_word());
        4: begin
          // Idle key change: wait for the block to drain first.
          in_ch.valid <= 1'b0;
          wait (pending_words == 0);
          @(posedge clk);
          load_key(pick_word(), pick_word());
        end
        default: send_operands(2);
      endcase
    end
    in_ch.valid <= 1'b0;

    wait (pending_words == 0);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("covered %0d input items and %0d checked products", items_sent, products_seen);
    $display("keys reloaded at random, ignored opcodes and stalls on both sides included");
    if (fail_count == 0 && pending_words == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
